// ===== rtl/plob_pkg.sv =====
// Shared types and constants for the price level order book.
package plob_pkg;

    localparam int SUM_W   = 38;
    localparam int OUT_P_W = 32;
    localparam int OUT_S_W = 32;
    localparam int EDGE_W  = 33;

    typedef struct packed {
        logic ins;
        logic del;
        logic upd;
    } cell_ctrl_t;

    typedef struct packed {
        logic en;
        logic clr;
    } side_ctrl_t;

endpackage

// ===== rtl/plob_cell.sv =====
// One price level slot of a sorted side chain.
module plob_cell #(
    parameter int PRICE_BITS = 32,
    parameter int SIZE_BITS  = 32,
    parameter bit DESC       = 1'b1
) (
    input  logic                    clk,
    input  plob_pkg::cell_ctrl_t    ctrl,
    input  logic                    occ,
    input  logic [PRICE_BITS-1:0]   op_price,
    input  logic [SIZE_BITS-1:0]    op_size,
    input  logic                    prev_ahead,
    input  logic [PRICE_BITS-1:0]   prev_price,
    input  logic [SIZE_BITS-1:0]    prev_size,
    input  logic [PRICE_BITS-1:0]   next_price,
    input  logic [SIZE_BITS-1:0]    next_size,
    output logic                    ahead,
    output logic                    match,
    output logic [PRICE_BITS-1:0]   price,
    output logic [SIZE_BITS-1:0]    size
);

    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;

    // ahead: this level sorts strictly before the incoming price
    assign ahead = occ && (DESC ? (price_reg > op_price) : (price_reg < op_price));
    assign match = occ && (price_reg == op_price);
    assign price = price_reg;
    assign size  = size_reg;

    always_comb
    begin
        price_next = price_reg;
        size_next  = size_reg;
        if (ctrl.ins && !ahead)
        begin
            if (prev_ahead)
            begin
                price_next = op_price;
                size_next  = op_size;
            end
            else
            begin
                price_next = prev_price;
                size_next  = prev_size;
            end
        end
        else if (ctrl.del && !ahead)
        begin
            price_next = next_price;
            size_next  = next_size;
        end
        else if (ctrl.upd && match)
        begin
            size_next = op_size;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        size_reg  <= size_next;
    end

endmodule

// ===== rtl/plob_side.sv =====
// One side of the book: a sorted chain of level cells with count and size sum.
module plob_side #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 32,
    parameter int SIZE_BITS  = 32,
    parameter bit DESC       = 1'b1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  plob_pkg::side_ctrl_t            ctrl,
    input  logic [PRICE_BITS-1:0]           op_price,
    input  logic [SIZE_BITS-1:0]            op_size,
    output logic                            nonempty,
    output logic [PRICE_BITS-1:0]           top_price,
    output logic [SIZE_BITS-1:0]            top_size,
    output logic [plob_pkg::SUM_W-1:0]      sum,
    output logic                            dropped
);

    localparam int CW = $clog2(LEVELS + 1);

    logic [CW-1:0]                  count_reg, count_next;
    logic [plob_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [LEVELS-1:0]              occ, ahead, match;
    logic [PRICE_BITS-1:0]          cp [LEVELS];
    logic [SIZE_BITS-1:0]           cs [LEVELS];
    logic [SIZE_BITS-1:0]           old_size;
    logic                           found, full, size_nz;
    logic [plob_pkg::SUM_W-1:0]     old_ext, new_ext;
    plob_pkg::cell_ctrl_t           cctrl;

    assign found   = |match;
    assign full    = (count_reg == CW'(LEVELS));
    assign size_nz = (op_size != '0);

    assign cctrl.ins = ctrl.en && size_nz && !found && !full;
    assign cctrl.upd = ctrl.en && size_nz && found;
    assign cctrl.del = ctrl.en && !size_nz && found;
    assign dropped   = ctrl.en && size_nz && !found && full;

    // match is one-hot, so an OR of the gated sizes picks the old one
    always_comb
    begin
        old_size = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            old_size = old_size | (cs[i] & {SIZE_BITS{match[i]}});
        end
    end

    assign old_ext = plob_pkg::SUM_W'(old_size);
    assign new_ext = plob_pkg::SUM_W'(op_size);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (ctrl.clr)
        begin
            count_next = '0;
            sum_next   = '0;
        end
        else if (cctrl.ins)
        begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + new_ext;
        end
        else if (cctrl.upd)
        begin
            sum_next = sum_reg - old_ext + new_ext;
        end
        else if (cctrl.del)
        begin
            count_next = count_reg - CW'(1);
            sum_next   = sum_reg - old_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        logic                  p_ahead;
        logic [PRICE_BITS-1:0] p_price, n_price;
        logic [SIZE_BITS-1:0]  p_size, n_size;

        assign occ[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign p_ahead = 1'b1;
            assign p_price = '0;
            assign p_size  = '0;
        end
        else
        begin : g_body
            assign p_ahead = ahead[i-1];
            assign p_price = cp[i-1];
            assign p_size  = cs[i-1];
        end

        if (i == LEVELS - 1)
        begin : g_tail
            assign n_price = '0;
            assign n_size  = '0;
        end
        else
        begin : g_link
            assign n_price = cp[i+1];
            assign n_size  = cs[i+1];
        end

        plob_cell #(
            .PRICE_BITS (PRICE_BITS),
            .SIZE_BITS  (SIZE_BITS),
            .DESC       (DESC)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cctrl),
            .occ        (occ[i]),
            .op_price   (op_price),
            .op_size    (op_size),
            .prev_ahead (p_ahead),
            .prev_price (p_price),
            .prev_size  (p_size),
            .next_price (n_price),
            .next_size  (n_size),
            .ahead      (ahead[i]),
            .match      (match[i]),
            .price      (cp[i]),
            .size       (cs[i])
        );
    end

    assign nonempty  = (count_reg != '0);
    assign top_price = cp[0];
    assign top_size  = cs[0];
    assign sum       = sum_reg;

endmodule

// ===== rtl/price_level_order_book_top.sv =====
// Top level of the two-sided price level order book.
// A transfer passes operand capture, chain update and result register in that order; done pulses as
// the result register loads, and busy stays high until then, so a new transfer waits for the last one.
// In the chain update the selected side inserts, replaces or deletes one level, or a clear empties both sides.
// Reset clears the state, level counts, size sums, result strobe and result registers; level storage is not reset.
// Results are shown on done for one cycle; the receiver cannot stall.
module price_level_order_book_top #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 32,
    parameter int SIZE_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic                side,
    input  logic [31:0]         price,
    input  logic [31:0]         size,
    output logic                done,
    output logic                bid_valid,
    output logic [31:0]         best_bid_price,
    output logic [31:0]         best_bid_size,
    output logic                ask_valid,
    output logic [31:0]         best_ask_price,
    output logic [31:0]         best_ask_size,
    output logic signed [32:0]  spread_ticks,
    output logic [32:0]         mid_price_doubled,
    output logic [37:0]         bid_total_size,
    output logic [37:0]         ask_total_size,
    output logic                insert_dropped
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } state_t;

    state_t                         state_reg;
    logic                           func_reg, side_reg;
    logic [PRICE_BITS-1:0]          price_reg;
    logic [SIZE_BITS-1:0]           size_reg;
    logic                           drop_reg;
    logic                           done_reg;
    logic                           bv_reg, av_reg, ins_drop_reg;
    logic [plob_pkg::OUT_P_W-1:0]   bp_reg, ap_reg;
    logic [plob_pkg::OUT_S_W-1:0]   bs_reg, as_reg;
    logic [plob_pkg::EDGE_W-1:0]    spread_reg, mid_reg;
    logic [plob_pkg::SUM_W-1:0]     bsum_reg, asum_reg;

    plob_pkg::side_ctrl_t           bctrl, actrl;
    logic                           b_ne, a_ne, b_drop, a_drop;
    logic [PRICE_BITS-1:0]          b_tp, a_tp;
    logic [SIZE_BITS-1:0]           b_ts, a_ts;
    logic [plob_pkg::SUM_W-1:0]     b_sum, a_sum;

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg  <= func;
            side_reg  <= side;
            price_reg <= PRICE_BITS'(price);
            size_reg  <= SIZE_BITS'(size);
        end
    end

    assign bctrl.en  = (state_reg == ST_EXEC) && !func_reg && !side_reg;
    assign actrl.en  = (state_reg == ST_EXEC) && !func_reg && side_reg;
    assign bctrl.clr = (state_reg == ST_EXEC) && func_reg;
    assign actrl.clr = (state_reg == ST_EXEC) && func_reg;

    plob_side #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .SIZE_BITS  (SIZE_BITS),
        .DESC       (1'b1)
    ) u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (bctrl),
        .op_price   (price_reg),
        .op_size    (size_reg),
        .nonempty   (b_ne),
        .top_price  (b_tp),
        .top_size   (b_ts),
        .sum        (b_sum),
        .dropped    (b_drop)
    );

    plob_side #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS),
        .SIZE_BITS  (SIZE_BITS),
        .DESC       (1'b0)
    ) u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (actrl),
        .op_price   (price_reg),
        .op_size    (size_reg),
        .nonempty   (a_ne),
        .top_price  (a_tp),
        .top_size   (a_ts),
        .sum        (a_sum),
        .dropped    (a_drop)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            drop_reg     <= 1'b0;
            done_reg     <= 1'b0;
            bv_reg       <= 1'b0;
            av_reg       <= 1'b0;
            ins_drop_reg <= 1'b0;
            bp_reg       <= '0;
            bs_reg       <= '0;
            ap_reg       <= '0;
            as_reg       <= '0;
            spread_reg   <= '0;
            mid_reg      <= '0;
            bsum_reg     <= '0;
            asum_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    drop_reg  <= b_drop || a_drop;
                    state_reg <= ST_REPORT;
                end
                ST_REPORT:
                begin
                    done_reg     <= 1'b1;
                    bv_reg       <= b_ne;
                    av_reg       <= a_ne;
                    ins_drop_reg <= drop_reg;
                    bp_reg       <= b_ne ? plob_pkg::OUT_P_W'(b_tp) : '0;
                    bs_reg       <= b_ne ? plob_pkg::OUT_S_W'(b_ts) : '0;
                    ap_reg       <= a_ne ? plob_pkg::OUT_P_W'(a_tp) : '0;
                    as_reg       <= a_ne ? plob_pkg::OUT_S_W'(a_ts) : '0;
                    // both edges are zero-extended to 33 bits; a crossed book gives a negative spread
                    spread_reg   <= (b_ne && a_ne) ?
                                    (plob_pkg::EDGE_W'(a_tp) - plob_pkg::EDGE_W'(b_tp)) : '0;
                    mid_reg      <= (b_ne && a_ne) ?
                                    (plob_pkg::EDGE_W'(a_tp) + plob_pkg::EDGE_W'(b_tp)) : '0;
                    bsum_reg     <= b_sum;
                    asum_reg     <= a_sum;
                    state_reg    <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done              = done_reg;
    assign bid_valid         = bv_reg;
    assign best_bid_price    = bp_reg;
    assign best_bid_size     = bs_reg;
    assign ask_valid         = av_reg;
    assign best_ask_price    = ap_reg;
    assign best_ask_size     = as_reg;
    assign spread_ticks      = signed'(spread_reg);
    assign mid_price_doubled = mid_reg;
    assign bid_total_size    = bsum_reg;
    assign ask_total_size    = asum_reg;
    assign insert_dropped    = ins_drop_reg;

`ifndef SYNTH
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing after a start transfer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while block still busy");

    a_drop_update_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && func_reg) |=> !drop_reg)
        else $error("drop flagged on a clear");
`endif

endmodule
